>>> rtl/core/utf8d_pkg.sv
// Shared types and constants for the UTF-8 stream decoder.
// Used by utf8d_decode, utf8d_burst and utf8_stream_decoder; no dependencies.
package utf8d_pkg;

  localparam int CP_W    = 31;
  localparam int MAX_RES = 6;
  localparam int CNT_W   = 3;

  localparam logic [7:0] LEAD_MIN   = 8'hC0;
  localparam logic [7:0] STAND_MIN  = 8'hFE;
  localparam logic [7:0] MASK_E0    = 8'hE0;
  localparam logic [7:0] MASK_F0    = 8'hF0;
  localparam logic [7:0] MASK_F8    = 8'hF8;
  localparam logic [7:0] MASK_FC    = 8'hFC;
  localparam logic [7:0] PAT_2BYTE  = 8'hC0;
  localparam logic [7:0] PAT_3BYTE  = 8'hE0;
  localparam logic [7:0] PAT_4BYTE  = 8'hF0;
  localparam logic [7:0] PAT_5BYTE  = 8'hF8;
  localparam logic [1:0] CONT_TAG   = 2'b10;
  localparam logic [5:0] PAYLOAD_M  = 6'h3F;
  localparam logic [4:0] LEAD2_M    = 5'h1F;

  typedef struct packed {
    logic [CP_W-1:0] code_point;
    logic            raw;
  } entry_t;

  typedef struct packed {
    entry_t [MAX_RES-1:0] ent;
    logic [CNT_W-1:0]     count;
    logic                 eos;
  } burst_t;

endpackage

>>> rtl/core/utf8_stream_decoder.sv
// Top level of the UTF-8 stream decoder: input register, decoder and result buffer.
// Depends on utf8d_pkg, utf8d_decode and utf8d_burst.
//
// One byte enters per transfer on the in_ channel, with in_end_of_string on the
// last byte of a string. Results leave on the out_ channel, one code point or
// raw byte per transfer; out_run_last marks the last result of an input byte and
// out_string_last the final result of a string. A lead byte without the flag
// produces no result. A broken or unfinished sequence yields up to six results.
// Each byte passes the input register and then the result buffer. Throughput
// is one byte per cycle while each byte gives at most one result and out_ready
// stays high; a byte with several results occupies the result buffer until the
// last is taken, while one further byte waits in the input register. When the
// receiver stalls, the buffer and then the input register fill and in_ready drops.
// Reset clears the open sequence and empties both registers, ready to start a new string.
module utf8_stream_decoder (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 in_byte,
  input  logic                       in_end_of_string,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [utf8d_pkg::CP_W-1:0] out_code_point,
  output logic                       out_raw_fallback,
  output logic                       out_run_last,
  output logic                       out_string_last
);

  logic              hold_valid_r;
  logic [7:0]        hold_byte_r;
  logic              hold_eos_r;
  logic              can_load;
  logic              advance;
  utf8d_pkg::burst_t burst;

  assign advance  = hold_valid_r && can_load;
  assign in_ready = !hold_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else if (in_ready) begin
      hold_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      hold_byte_r <= in_byte;
      hold_eos_r  <= in_end_of_string;
    end
  end

  utf8d_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .byte_in (hold_byte_r),
    .eos_in  (hold_eos_r),
    .burst   (burst)
  );

  utf8d_burst u_burst (
    .clk              (clk),
    .rst_n            (rst_n),
    .load             (advance),
    .burst            (burst),
    .can_load         (can_load),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_code_point   (out_code_point),
    .out_raw_fallback (out_raw_fallback),
    .out_run_last     (out_run_last),
    .out_string_last  (out_string_last)
  );

endmodule

>>> rtl/core/utf8d_decode.sv
// Sequence state and combinational decode of one byte into a burst of results.
// Depends on utf8d_pkg for the burst type and byte constants.
module utf8d_decode (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                advance,
  input  logic [7:0]          byte_in,
  input  logic                eos_in,
  output utf8d_pkg::burst_t   burst
);

  logic [7:0]                 lead_r, lead_nxt;
  logic [2:0]                 exp_r, exp_nxt;
  logic [2:0]                 seen_r, seen_nxt;
  logic [utf8d_pkg::CP_W-1:0] acc_r, acc_nxt;

  logic                       open_seq, is_cont, complete, standalone;
  logic [2:0]                 seen_c, need;
  logic [utf8d_pkg::CP_W-1:0] acc_c, lead_bits;
  logic                       flush_en, tail_en, tail_raw;
  logic [7:0]                 flead;
  logic [2:0]                 fseen;
  logic [utf8d_pkg::CP_W-1:0] faccum, tail_cp;

  always_comb begin
    open_seq   = (exp_r != 3'd0);
    is_cont    = (byte_in[7:6] == utf8d_pkg::CONT_TAG);
    acc_c      = {acc_r[utf8d_pkg::CP_W-7:0], byte_in[5:0] & utf8d_pkg::PAYLOAD_M};
    seen_c     = seen_r + 3'd1;
    complete   = (seen_c >= exp_r);
    standalone = (byte_in < utf8d_pkg::LEAD_MIN) || (byte_in >= utf8d_pkg::STAND_MIN);

    if ((byte_in & utf8d_pkg::MASK_E0) == utf8d_pkg::PAT_2BYTE) begin
      need      = 3'd1;
      lead_bits = {26'd0, byte_in[4:0] & utf8d_pkg::LEAD2_M};
    end else if ((byte_in & utf8d_pkg::MASK_F0) == utf8d_pkg::PAT_3BYTE) begin
      need      = 3'd2;
      lead_bits = {27'd0, byte_in[3:0]};
    end else if ((byte_in & utf8d_pkg::MASK_F8) == utf8d_pkg::PAT_4BYTE) begin
      need      = 3'd3;
      lead_bits = {28'd0, byte_in[2:0]};
    end else if ((byte_in & utf8d_pkg::MASK_FC) == utf8d_pkg::PAT_5BYTE) begin
      need      = 3'd4;
      lead_bits = {29'd0, byte_in[1:0]};
    end else begin
      need      = 3'd5;
      lead_bits = {30'd0, byte_in[0]};
    end

    flush_en = 1'b0;
    flead    = lead_r;
    fseen    = seen_r;
    faccum   = acc_r;
    tail_en  = 1'b0;
    tail_cp  = {23'd0, byte_in};
    tail_raw = 1'b0;
    lead_nxt = 8'd0;
    exp_nxt  = 3'd0;
    seen_nxt = 3'd0;
    acc_nxt  = '0;

    if (open_seq && is_cont) begin
      if (complete) begin
        tail_en = 1'b1;
        tail_cp = acc_c;
      end else if (eos_in) begin
        flush_en = 1'b1;
        fseen    = seen_c;
        faccum   = acc_c;
      end else begin
        lead_nxt = lead_r;
        exp_nxt  = exp_r;
        seen_nxt = seen_c;
        acc_nxt  = acc_c;
      end
    end else begin
      flush_en = open_seq;
      if (standalone) begin
        tail_en = 1'b1;
      end else if (eos_in) begin
        tail_en  = 1'b1;
        tail_raw = 1'b1;
      end else begin
        lead_nxt = byte_in;
        exp_nxt  = need;
        acc_nxt  = lead_bits;
      end
    end

    if (eos_in) begin
      lead_nxt = 8'd0;
      exp_nxt  = 3'd0;
      seen_nxt = 3'd0;
      acc_nxt  = '0;
    end
  end

  always_comb begin
    logic [2:0]                 base;
    logic [2:0]                 d;
    logic [4:0]                 sh;
    logic [utf8d_pkg::CP_W-1:0] shifted;
    base = flush_en ? (fseen + 3'd1) : 3'd0;
    for (int k = 0; k < utf8d_pkg::MAX_RES; k++) begin
      d       = fseen - 3'(k);
      sh      = {2'b00, d} * 5'd6;
      shifted = faccum >> sh;
      burst.ent[k].code_point = tail_cp;
      burst.ent[k].raw        = tail_raw;
      if (flush_en && (3'(k) <= fseen)) begin
        burst.ent[k].raw = 1'b1;
        if (k == 0) begin
          burst.ent[k].code_point = {23'd0, flead};
        end else begin
          burst.ent[k].code_point = {23'd0, utf8d_pkg::CONT_TAG, shifted[5:0]};
        end
      end
    end
    burst.count = base + {2'b00, tail_en};
    burst.eos   = eos_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lead_r <= 8'd0;
      exp_r  <= 3'd0;
      seen_r <= 3'd0;
      acc_r  <= '0;
    end else if (advance) begin
      lead_r <= lead_nxt;
      exp_r  <= exp_nxt;
      seen_r <= seen_nxt;
      acc_r  <= acc_nxt;
    end
  end

endmodule

>>> rtl/core/utf8d_burst.sv
// Result buffer that holds one burst and shifts it out one transfer at a time.
// Depends on utf8d_pkg for the burst and entry types.
module utf8d_burst (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       load,
  input  utf8d_pkg::burst_t          burst,
  output logic                       can_load,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [utf8d_pkg::CP_W-1:0] out_code_point,
  output logic                       out_raw_fallback,
  output logic                       out_run_last,
  output logic                       out_string_last
);

  utf8d_pkg::entry_t [utf8d_pkg::MAX_RES-1:0] ent_r;
  logic [utf8d_pkg::CNT_W-1:0]                cnt_r;
  logic                                       eos_r;
  logic                                       fire;

  assign out_valid        = (cnt_r != '0);
  assign fire             = out_valid && out_ready;
  assign can_load         = (cnt_r == '0) || ((cnt_r == utf8d_pkg::CNT_W'(1)) && out_ready);
  assign out_code_point   = ent_r[0].code_point;
  assign out_raw_fallback = ent_r[0].raw;
  assign out_run_last     = (cnt_r == utf8d_pkg::CNT_W'(1));
  assign out_string_last  = (cnt_r == utf8d_pkg::CNT_W'(1)) && eos_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (load) begin
      cnt_r <= burst.count;
    end else if (fire) begin
      cnt_r <= cnt_r - utf8d_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ent_r <= burst.ent;
      eos_r <= burst.eos;
    end else if (fire) begin
      for (int k = 0; k < utf8d_pkg::MAX_RES - 1; k++) begin
        ent_r[k] <= ent_r[k+1];
      end
    end
  end

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// Testbench for utf8_stream_decoder: directed and random byte strings with random
// idling on both channels, checked against a cycle-free decoder model kept here.
// Depends on utf8d_pkg and the utf8_stream_decoder RTL.
module tb;

  localparam int WATCHDOG_LIMIT = 1000;

  typedef struct packed {
    logic [utf8d_pkg::CP_W-1:0] code_point;
    logic                       raw_fallback;
    logic                       run_last;
    logic                       string_last;
  } cp_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] in_byte = 8'h00;
  logic in_end_of_string = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [utf8d_pkg::CP_W-1:0] out_code_point;
  logic out_raw_fallback;
  logic out_run_last;
  logic out_string_last;

  // Decoder state of the model.
  logic [7:0] seq_lead = 8'h00;
  logic [2:0] seq_need = 3'd0;
  logic [2:0] seq_seen = 3'd0;
  logic [utf8d_pkg::CP_W-1:0] seq_accum = '0;

  cp_result_t byte_results [0:utf8d_pkg::MAX_RES-1];
  int byte_result_count;
  cp_result_t pending_code_points[$];
  logic [7:0] string_bytes[$];

  int errors = 0;
  int items_sent = 0;
  int idle_cycles = 0;
  int hold_cycles = 0;
  bit tx_idle_on = 1'b1;
  bit rx_idle_on = 1'b1;

  utf8_stream_decoder uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_byte(in_byte),
    .in_end_of_string(in_end_of_string),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_code_point(out_code_point),
    .out_raw_fallback(out_raw_fallback),
    .out_run_last(out_run_last),
    .out_string_last(out_string_last)
  );

  always #1 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic void add_result(input logic [utf8d_pkg::CP_W-1:0] cp, input logic raw);
    cp_result_t r;
    r.code_point = cp;
    r.raw_fallback = raw;
    r.run_last = 1'b0;
    r.string_last = 1'b0;
    if (byte_result_count < utf8d_pkg::MAX_RES) begin
      byte_results[byte_result_count] = r;
      byte_result_count++;
    end
  endfunction

  function automatic void close_sequence();
    seq_lead = 8'h00;
    seq_need = 3'd0;
    seq_seen = 3'd0;
    seq_accum = '0;
  endfunction

  // A broken or unfinished sequence comes back as its original bytes.
  function automatic void flush_sequence();
    int i;
    logic [utf8d_pkg::CP_W-1:0] shifted;
    add_result({23'd0, seq_lead}, 1'b1);
    for (i = 1; i <= seq_seen; i++) begin
      shifted = seq_accum >> (6 * (seq_seen - i));
      add_result({23'd0, utf8d_pkg::CONT_TAG, shifted[5:0]}, 1'b1);
    end
    close_sequence();
  endfunction

  function automatic void start_byte(input logic [7:0] b, input logic last);
    logic [2:0] need;
    if (b < utf8d_pkg::LEAD_MIN || b >= utf8d_pkg::STAND_MIN) begin
      add_result({23'd0, b}, 1'b0);
    end else begin
      if ((b & utf8d_pkg::MASK_E0) == utf8d_pkg::PAT_2BYTE) need = 3'd1;
      else if ((b & utf8d_pkg::MASK_F0) == utf8d_pkg::PAT_3BYTE) need = 3'd2;
      else if ((b & utf8d_pkg::MASK_F8) == utf8d_pkg::PAT_4BYTE) need = 3'd3;
      else if ((b & utf8d_pkg::MASK_FC) == utf8d_pkg::PAT_5BYTE) need = 3'd4;
      else need = 3'd5;
      seq_lead = b;
      seq_need = need;
      seq_seen = 3'd0;
      seq_accum = {23'd0, b & (8'h3F >> need)};
      if (last) flush_sequence();
    end
  endfunction

  function automatic void decode_byte(input logic [7:0] b, input logic last);
    int i;
    byte_result_count = 0;
    if (seq_need != 3'd0) begin
      if (b[7:6] == utf8d_pkg::CONT_TAG) begin
        seq_accum = {seq_accum[utf8d_pkg::CP_W-7:0], b[5:0]};
        seq_seen = seq_seen + 3'd1;
        if (seq_seen >= seq_need) begin
          add_result(seq_accum, 1'b0);
          close_sequence();
        end else if (last) begin
          flush_sequence();
        end
      end else begin
        flush_sequence();
        start_byte(b, last);
      end
    end else begin
      start_byte(b, last);
    end
    if (last) close_sequence();
    if (byte_result_count > 0) begin
      byte_results[byte_result_count-1].run_last = 1'b1;
      byte_results[byte_result_count-1].string_last = last;
    end
    for (i = 0; i < byte_result_count; i++) pending_code_points.push_back(byte_results[i]);
  endfunction

  task automatic send_byte(input logic [7:0] value, input logic last);
    int gap;
    gap = tx_idle_on ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= value;
    in_end_of_string <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    decode_byte(value, last);
    items_sent++;
  endtask

  task automatic send_string();
    int i;
    for (i = 0; i < string_bytes.size(); i++) begin
      send_byte(string_bytes[i], i == string_bytes.size() - 1);
    end
  endtask

  // Appends one character of n bytes, cut short after keep bytes when keep < n.
  task automatic add_character(input int n, input int keep);
    int bits, k;
    logic [31:0] cp;
    logic [31:0] part;
    bits = (n == 1) ? 7 : 5 * n + 1;
    cp = $urandom & ((32'h1 << bits) - 1);
    if (n == 1) begin
      string_bytes.push_back(cp[7:0]);
    end else begin
      part = cp >> (6 * (n - 1));
      string_bytes.push_back((8'hFF << (8 - n)) | part[7:0]);
      for (k = 1; k < keep; k++) begin
        part = cp >> (6 * (n - 1 - k));
        string_bytes.push_back({utf8d_pkg::CONT_TAG, part[5:0]});
      end
    end
  endtask

  task automatic build_random_string();
    int units, u, n, keep;
    string_bytes.delete();
    units = $urandom_range(1, 8);
    for (u = 0; u < units; u++) begin
      if ($urandom_range(0, 99) < 10) begin
        string_bytes.push_back(8'($urandom_range(0, 255)));
      end else begin
        n = $urandom_range(1, 6);
        keep = n;
        if (n > 1 && $urandom_range(0, 99) < 15) keep = $urandom_range(1, n - 1);
        add_character(n, keep);
      end
    end
  endtask

  task automatic test_standalone_bytes();
    string_bytes = '{8'h00, 8'h7F, 8'hBF, 8'hFE, 8'hFF};
    send_string();
  endtask

  task automatic test_longest_sequence();
    string_bytes = '{8'hFD, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF};
    send_string();
  endtask

  task automatic test_broken_sequences();
    string_bytes = '{8'hC2, 8'hA9, 8'hFD, 8'h80, 8'h80, 8'h80, 8'h80, 8'h41,
                     8'hE2, 8'h82, 8'hFC};
    send_string();
    string_bytes = '{8'hC3};
    send_string();
  endtask

  task automatic test_random_strings();
    int start;
    start = items_sent;
    while (items_sent - start < 290) begin
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      build_random_string();
      send_string();
    end
  endtask

  task automatic test_output_backpressure();
    int start;
    start = items_sent;
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    hold_cycles = 200;
    while (items_sent - start < 40) begin
      build_random_string();
      send_string();
    end
  endtask

  initial begin : receiver
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        hold_cycles--;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if (rx_idle_on) stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin : result_check
    cp_result_t got;
    cp_result_t want;
    if (rst_n && out_valid && out_ready) begin
      got.code_point = out_code_point;
      got.raw_fallback = out_raw_fallback;
      got.run_last = out_run_last;
      got.string_last = out_string_last;
      if (pending_code_points.size() == 0) begin
        errors++;
        $display("%0t: unexpected result cp=%h raw=%b run_last=%b string_last=%b", $time,
                 got.code_point, got.raw_fallback, got.run_last, got.string_last);
      end else begin
        want = pending_code_points.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t: mismatch expected cp=%h raw=%b run_last=%b string_last=%b", $time,
                   want.code_point, want.raw_fallback, want.run_last, want.string_last);
          $display("%0t:          actual   cp=%h raw=%b run_last=%b string_last=%b", $time,
                   got.code_point, got.raw_fallback, got.run_last, got.string_last);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    test_standalone_bytes();
    test_longest_sequence();
    test_broken_sequences();
    test_random_strings();
    test_output_backpressure();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_code_points.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/core/utf8d_pkg.sv
rtl/core/utf8d_decode.sv
rtl/core/utf8d_burst.sv
rtl/core/utf8_stream_decoder.sv
tb/tb.sv
